/* design/tsa_pkg.sv */
// ----------------------------------------------------------------------------
// tsa_pkg: shared types and constants of the TLB slot allocator
// Request and result words, field widths and the invalid entry pattern.
// ----------------------------------------------------------------------------
package tsa_pkg;

    localparam int SLOT_W    = 6;
    localparam int WORD_W    = 32;
    localparam int PAGE_BITS = 12;
    localparam int TAG_W     = WORD_W - PAGE_BITS;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_CLEAN = 1'b1;

    localparam logic [TAG_W-1:0] INVALID_HI_BASE = TAG_W'(20'h80000);

    typedef struct packed {
        logic              mode;
        logic              has_slot;
        logic [SLOT_W-1:0] given_slot;
        logic [WORD_W-1:0] entry_hi;
        logic [WORD_W-1:0] entry_lo;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              replaced;
        logic [WORD_W-1:0] write_hi;
        logic [WORD_W-1:0] write_lo;
    } t_res;

endpackage

/* design/tlb_slot_allocator_top.sv */
// ----------------------------------------------------------------------------
// tlb_slot_allocator_top: translation buffer slot allocator
// Request word in, slot and entry words out; one request per cycle unless the receiver stalls.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries a request word: a write
// that names its slot or lets the block choose, or a clean of one slot.
// Output channel (o_out_valid / i_out_ready) returns one result word per
// request: the slot, the replacement flag and the words to store.
// A request is held in the input register; the map lookup and update happen
// together with the load of the result register. Throughput is one word per
// cycle while the receiver does not stall, set by the map update between
// those two registers.
// When the receiver stalls, the result register holds its word, the input
// register holds the next request, and o_in_ready drops once both are full.
// Reset clears the occupancy map, the victim pointer and both valid flags.
// ----------------------------------------------------------------------------
module tlb_slot_allocator_top #(
    parameter int NUM_SLOTS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_mode,
    input  logic                        i_has_slot,
    input  logic [tsa_pkg::SLOT_W-1:0]  i_given_slot,
    input  logic [tsa_pkg::WORD_W-1:0]  i_entry_hi,
    input  logic [tsa_pkg::WORD_W-1:0]  i_entry_lo,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [tsa_pkg::SLOT_W-1:0]  o_slot,
    output logic                        o_replaced,
    output logic [tsa_pkg::WORD_W-1:0]  o_write_hi,
    output logic [tsa_pkg::WORD_W-1:0]  o_write_lo
);
    import tsa_pkg::*;

    logic r_in_vld;
    t_req r_req;
    logic r_out_vld;
    t_res r_res;
    t_res alloc_res;
    logic advance;
    logic fire;

    assign advance    = !r_out_vld || i_out_ready;
    assign fire       = r_in_vld && advance;
    assign o_in_ready = !r_in_vld || advance;

    tsa_alloc #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_alloc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (r_req),
        .o_res   (alloc_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req.mode       <= i_mode;
            r_req.has_slot   <= i_has_slot;
            r_req.given_slot <= i_given_slot;
            r_req.entry_hi   <= i_entry_hi;
            r_req.entry_lo   <= i_entry_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= alloc_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_slot      = r_res.slot;
    assign o_replaced  = r_res.replaced;
    assign o_write_hi  = r_res.write_hi;
    assign o_write_lo  = r_res.write_lo;

endmodule

/* design/tsa_alloc.sv */
// ----------------------------------------------------------------------------
// tsa_alloc: occupancy map, victim pointer and slot selection
// Uses the given slot, else picks the lowest free slot or a round-robin victim, and updates the map.
// ----------------------------------------------------------------------------
module tsa_alloc #(
    parameter int NUM_SLOTS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  tsa_pkg::t_req i_req,
    output tsa_pkg::t_res o_res
);
    import tsa_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int NUM_CODES = 1 << SLOT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    logic [NUM_SLOTS-1:0] r_map;
    logic [NUM_SLOTS-1:0] n_map;
    logic [IDX_W-1:0]     r_victim;
    logic [IDX_W-1:0]     n_victim;

    logic [IDX_W-1:0]     mod_tbl [NUM_CODES];
    logic [IDX_W-1:0]     given_idx;
    logic [IDX_W-1:0]     free_idx;
    logic                 any_free;
    logic [IDX_W-1:0]     sel_idx;
    logic                 replace;
    logic [NUM_SLOTS-1:0] free_bits;
    logic [TAG_W-1:0]     inv_tag;

    for (genvar g = 0; g < NUM_CODES; g++) begin : g_mod
        assign mod_tbl[g] = IDX_W'(g % NUM_SLOTS);
    end

    assign given_idx = mod_tbl[i_req.given_slot];
    assign free_bits = ~r_map;
    assign any_free  = |free_bits;

    always_comb begin
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        replace = 1'b0;
        sel_idx = given_idx;
        if (!i_req.has_slot) begin
            if (any_free) begin
                sel_idx = free_idx;
            end else begin
                sel_idx = r_victim;
                replace = 1'b1;
            end
        end
    end

    always_comb begin
        n_map    = r_map;
        n_victim = r_victim;
        if (i_req.mode == MODE_CLEAN) begin
            n_map[given_idx] = 1'b0;
        end else begin
            n_map[sel_idx] = 1'b1;
            if (replace) begin
                n_victim = (r_victim == LAST_IDX) ? '0 : r_victim + 1'b1;
            end
        end
    end

    assign inv_tag = INVALID_HI_BASE + TAG_W'(given_idx);

    always_comb begin
        if (i_req.mode == MODE_CLEAN) begin
            o_res.slot     = SLOT_W'(given_idx);
            o_res.replaced = 1'b0;
            o_res.write_hi = {inv_tag, {PAGE_BITS{1'b0}}};
            o_res.write_lo = '0;
        end else begin
            o_res.slot     = SLOT_W'(sel_idx);
            o_res.replaced = replace;
            o_res.write_hi = i_req.entry_hi;
            o_res.write_lo = i_req.entry_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map    <= '0;
            r_victim <= '0;
        end else if (i_fire) begin
            r_map    <= n_map;
            r_victim <= n_victim;
        end
    end

endmodule
